FILE: design/intel_hex_record_parser_unit_defines.svh
// ---------------------------------------------------------------------------
// Intel HEX record parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_PARSER_UNIT_DEFINES_SVH
`define INTEL_HEX_RECORD_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IHEX_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IHEX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ihex_pkg.sv
// ---------------------------------------------------------------------------
// Intel HEX record parser package
// Shared widths, result kinds, the result structure and the digit decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

	localparam int unsigned IDX_W = 16;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_NOEND = 2'd2;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF    = 8'h66;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;
	localparam logic [7:0] DIGIT_BAD  = 8'hFF;
	localparam logic [7:0] DIGIT_TEN  = 8'h0A;
	localparam logic [7:0] NIBBLE_MSK = 8'h0F;

	typedef struct packed {
		logic             valid;
		logic [1:0]       kind;
		logic [7:0]       data;
		logic [IDX_W-1:0] idx;
	} result_t;

	function automatic logic [7:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = DIGIT_BAD;
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				d = (c - CHAR_ZERO) & NIBBLE_MSK;
			end else if (c >= CHAR_LA && c <= CHAR_LF) begin
				d = (c - CHAR_LA + DIGIT_TEN) & NIBBLE_MSK;
			end else if (c >= CHAR_UA && c <= CHAR_UF) begin
				d = (c - CHAR_UA + DIGIT_TEN) & NIBBLE_MSK;
			end
			return d;
		end
	endfunction

endpackage

`default_nettype wire

FILE: design/ihex_core.sv
// ---------------------------------------------------------------------------
// Intel HEX record parser core
// Record state machine; consumes one registered character per firing cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "intel_hex_record_parser_unit_defines.svh"

module ihex_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     fire,
	input  wire logic [7:0]               char_in,
	input  wire logic                     end_of_input,
	input  wire logic [15:0]              buffer_length,
	output ihex_pkg::result_t             res
);

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_COUNT = 4'd1;
	localparam logic [3:0] PH_ADDR  = 4'd2;
	localparam logic [3:0] PH_TYPE  = 4'd3;
	localparam logic [3:0] PH_DATA  = 4'd4;
	localparam logic [3:0] PH_CHECK = 4'd5;
	localparam logic [3:0] PH_DONE  = 4'd6;

	logic [3:0]                 phase_q, phase_d;
	logic [2:0]                 step_q, step_d;
	logic [3:0]                 first_q, first_d;
	logic [7:0]                 len_q, len_d;
	logic [7:0]                 left_q, left_d;
	logic [ihex_pkg::IDX_W-1:0] widx_q, widx_d;
	logic [7:0]                 digit;
	logic [7:0]                 byte_val;

	assign digit    = ihex_pkg::hex_digit(char_in);
	assign byte_val = {first_q, 4'h0} | digit;

	always_comb begin
		phase_d = phase_q;
		step_d  = step_q;
		first_d = first_q;
		len_d   = len_q;
		left_d  = left_q;
		widx_d  = widx_q;
		res     = '0;
		if (phase_q == PH_DONE) begin
			res.valid = 1'b0;
		end else if (end_of_input) begin
			phase_d   = PH_DONE;
			res.valid = fire;
			res.kind  = ihex_pkg::KIND_NOEND;
		end else begin
			case (phase_q)
				PH_ADDR: begin
					step_d = step_q + 3'd1;
					if (step_d >= 3'd4) begin
						step_d  = 3'd0;
						phase_d = PH_TYPE;
					end
				end
				PH_COUNT, PH_TYPE, PH_DATA, PH_CHECK: begin
					if (step_q == 3'd0) begin
						first_d = digit[3:0];
						step_d  = 3'd1;
					end else begin
						step_d = 3'd0;
						case (phase_q)
							PH_COUNT: begin
								len_d   = byte_val;
								phase_d = PH_ADDR;
							end
							PH_TYPE: begin
								if (byte_val == ihex_pkg::REC_DATA) begin
									left_d  = len_q;
									phase_d = (len_q != 8'd0) ? PH_DATA : PH_CHECK;
								end else if (byte_val == ihex_pkg::REC_EOF) begin
									phase_d   = PH_DONE;
									res.valid = fire;
									res.kind  = ihex_pkg::KIND_END;
								end else begin
									phase_d = PH_CHECK;
								end
							end
							PH_DATA: begin
								if (widx_q < buffer_length) begin
									res.valid = fire;
									res.kind  = ihex_pkg::KIND_DATA;
									res.data  = byte_val;
									res.idx   = widx_q;
								end
								widx_d = widx_q + {{(ihex_pkg::IDX_W-1){1'b0}}, 1'b1};
								left_d = left_q - 8'd1;
								if (left_d == 8'd0) begin
									phase_d = PH_CHECK;
								end
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
				default: begin
					step_d  = 3'd0;
					phase_d = (char_in == ihex_pkg::CHAR_COLON) ? PH_COUNT : PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= 3'd0;
			first_q <= 4'd0;
			len_q   <= 8'd0;
			left_q  <= 8'd0;
			widx_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			step_q  <= step_d;
			first_q <= first_d;
			len_q   <= len_d;
			left_q  <= left_d;
			widx_q  <= widx_d;
		end
	end

	`IHEX_ASSERT_NEXT(a_done_sticks, phase_q == PH_DONE, phase_q == PH_DONE,
		"parser left the finished state")
	`IHEX_ASSERT_SAME(a_data_in_range, res.valid && res.kind == ihex_pkg::KIND_DATA,
		phase_q == PH_DATA && res.idx < buffer_length, "data write outside buffer")
	`IHEX_ASSERT_SAME(a_step_range, 1'b1, step_q < 3'd4, "digit step out of range")

endmodule

`default_nettype wire

FILE: design/intel_hex_record_parser_unit.sv
// A result reaches the master side through the input register and the result register.
// Throughput: one character per cycle unless the master side stalls; the parse state
// advances once per consumed character. A stalled result holds in the output register
// while one more character waits in the input register. Reset clears the parse state,
// the write index and both valid flags, and sets buffer_length to 65535.
// ---------------------------------------------------------------------------
// Intel HEX record parser unit
// Stream top level with input register, parser core and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "intel_hex_record_parser_unit_defines.svh"

module intel_hex_record_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        buffer_length_we,
	input  wire logic [15:0] buffer_length_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
	input  wire logic [0:0]  s_axis_tuser,   // [0] end_of_input
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [7:0] data_byte, [23:8] buffer_index
	output logic [1:0]       m_axis_tuser    // [1:0] kind
);

	logic [15:0]       blen_q;
	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              eoi_s1;
	logic              advance;
	logic              fire;
	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        data_q;
	logic [15:0]       idx_q;
	ihex_pkg::result_t res;

	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q <= 16'hFFFF;
		end else if (buffer_length_we) begin
			blen_q <= buffer_length_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			eoi_s1  <= s_axis_tuser[0];
		end
	end

	ihex_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.char_in       (char_s1),
		.end_of_input  (eoi_s1),
		.buffer_length (blen_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_q <= res.kind;
			data_q <= res.data;
			idx_q  <= res.idx;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {idx_q, data_q};
	assign m_axis_tuser  = kind_q;

	`IHEX_ASSERT_NEXT(a_s1_held, valid_s1 && !advance, valid_s1,
		"pending character dropped while output stalled")
	`IHEX_ASSERT_SAME(a_result_needs_input, res.valid, fire,
		"result produced without a consumed character")
	`IHEX_ASSERT_NEXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
		"stalled result dropped")

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// Intel HEX record parser testbench
// Streams characters into the parser and predicts each data byte write
// and the final end status from its own parse model. Results are checked in
// order. Stall patterns on both sides and the buffer length change between runs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] ADDR_DIGITS = 3'd4;
	localparam int LONG_HOLD = 200;
	localparam int SETTLE_CYCLES = 4;

	typedef enum logic [2:0] {
		ST_IDLE, ST_COUNT, ST_ADDR, ST_TYPE, ST_DATA, ST_CHECK, ST_DONE
	} parse_state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [ihex_pkg::IDX_W-1:0] idx;
	} hex_write_t;

	class hex_write_board_t;
		logic [15:0] buf_len;
		parse_state_t state;
		logic [2:0] digit_pos;
		logic [7:0] hi_nib;
		logic [7:0] rec_len;
		logic [7:0] bytes_left;
		logic [7:0] rec_type;
		logic [ihex_pkg::IDX_W-1:0] wr_idx;
		hex_write_t due_writes[$];
		int mismatches;

		function new();
			buf_len = 16'hFFFF;
			state = ST_IDLE;
			digit_pos = '0;
			hi_nib = '0;
			rec_len = '0;
			bytes_left = '0;
			rec_type = '0;
			wr_idx = '0;
			mismatches = 0;
		endfunction

		function logic [7:0] nibble_of(logic [7:0] c);
			if (c >= ihex_pkg::CHAR_ZERO && c <= ihex_pkg::CHAR_NINE)
				return c - ihex_pkg::CHAR_ZERO;
			if (c >= ihex_pkg::CHAR_LA && c <= ihex_pkg::CHAR_LF)
				return c - ihex_pkg::CHAR_LA + ihex_pkg::DIGIT_TEN;
			if (c >= ihex_pkg::CHAR_UA && c <= ihex_pkg::CHAR_UF)
				return c - ihex_pkg::CHAR_UA + ihex_pkg::DIGIT_TEN;
			return ihex_pkg::DIGIT_BAD;
		endfunction

		function void push_write(logic [1:0] kind, logic [7:0] data,
				logic [ihex_pkg::IDX_W-1:0] idx);
			hex_write_t w;
			w.kind = kind;
			w.data = data;
			w.idx = idx;
			due_writes.push_back(w);
		endfunction

		function void note_char(logic [7:0] c, logic eoi);
			logic [7:0] b;
			if (state == ST_DONE) return;
			if (eoi) begin
				state = ST_DONE;
				push_write(ihex_pkg::KIND_NOEND, '0, '0);
				return;
			end
			if (state == ST_ADDR) begin
				digit_pos = digit_pos + 3'd1;
				if (digit_pos >= ADDR_DIGITS) begin
					digit_pos = '0;
					state = ST_TYPE;
				end
				return;
			end
			if (state == ST_IDLE) begin
				digit_pos = '0;
				if (c == ihex_pkg::CHAR_COLON) state = ST_COUNT;
				return;
			end
			if (digit_pos == '0) begin
				hi_nib = nibble_of(c);
				digit_pos = 3'd1;
				return;
			end
			digit_pos = '0;
			b = {hi_nib[3:0], 4'h0} | nibble_of(c);
			case (state)
				ST_COUNT: begin
					rec_len = b;
					state = ST_ADDR;
				end
				ST_TYPE: begin
					rec_type = b;
					if (b == ihex_pkg::REC_DATA) begin
						bytes_left = rec_len;
						state = (rec_len != '0) ? ST_DATA : ST_CHECK;
					end else if (b == ihex_pkg::REC_EOF) begin
						state = ST_DONE;
						push_write(ihex_pkg::KIND_END, '0, '0);
					end else begin
						state = ST_CHECK;
					end
				end
				ST_DATA: begin
					if (wr_idx < buf_len) push_write(ihex_pkg::KIND_DATA, b, wr_idx);
					wr_idx = wr_idx + {{(ihex_pkg::IDX_W-1){1'b0}}, 1'b1};
					bytes_left = bytes_left - 8'd1;
					if (bytes_left == '0) state = ST_CHECK;
				end
				default: begin
					state = ST_IDLE;
				end
			endcase
		endfunction

		function void check_write(logic [1:0] kind, logic [7:0] data,
				logic [ihex_pkg::IDX_W-1:0] idx);
			hex_write_t w;
			if (due_writes.size() == 0) begin
				$error("unexpected result: kind %0d data %0h index %0d", kind, data, idx);
				mismatches++;
				return;
			end
			w = due_writes.pop_front();
			if (w.kind !== kind) begin
				$error("kind: expected %0d, actual %0d", w.kind, kind);
				mismatches++;
			end
			if (w.data !== data) begin
				$error("data_byte: expected %0h, actual %0h", w.data, data);
				mismatches++;
			end
			if (w.idx !== idx) begin
				$error("buffer_index: expected %0d, actual %0d", w.idx, idx);
				mismatches++;
			end
		endfunction

		function int pending();
			return due_writes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic buffer_length_we;
	logic [15:0] buffer_length_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic [0:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	hex_write_board_t board = new();
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit hold_req = 1'b0;
	int chars_sent = 0;

	intel_hex_record_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.buffer_length_we(buffer_length_we),
		.buffer_length_wdata(buffer_length_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb_top failed");
		$finish;
	end

	// The receiver either stalls at random or, on request, holds off for a long stretch.
	initial begin
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			board.check_write(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8]);
		end
	end

	function automatic logic [7:0] any_char();
		logic [7:0] ch;
		ch = 8'($urandom_range(255));
		return ch;
	endfunction

	function automatic logic [7:0] digit_char(logic [3:0] n);
		logic [7:0] ch;
		if (n < 4'd10) ch = ihex_pkg::CHAR_ZERO + n;
		else if ($urandom_range(1)) ch = ihex_pkg::CHAR_UA + (n - 4'd10);
		else ch = ihex_pkg::CHAR_LA + (n - 4'd10);
		return ch;
	endfunction

	function automatic logic [7:0] bad_digit_char();
		logic [7:0] ch;
		ch = any_char();
		while (board.nibble_of(ch) != ihex_pkg::DIGIT_BAD) ch = any_char();
		return ch;
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic eoi);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tuser <= eoi;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_char(ch, eoi);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
	endtask

	task automatic send_byte(input logic [7:0] b, input int bad_pct);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = ($urandom_range(99) < bad_pct) ? bad_digit_char() : digit_char(b[7:4]);
		lo = ($urandom_range(99) < bad_pct) ? bad_digit_char() : digit_char(b[3:0]);
		send_char(hi, 1'b0);
		send_char(lo, 1'b0);
	endtask

	// Broken headers only occur on non-data records, so a bad digit there never
	// turns into a huge data count or an end record.
	task automatic send_record(input logic [7:0] rtype, input logic [7:0] count,
			input int data_bad_pct, input bit bad_head);
		send_char(ihex_pkg::CHAR_COLON, 1'b0);
		send_byte(count, bad_head ? 50 : 0);
		repeat (ADDR_DIGITS) send_char($urandom_range(1) ? digit_char(4'($urandom_range(15)))
				: any_char(), 1'b0);
		send_byte(rtype, bad_head ? 50 : 0);
		if (rtype == ihex_pkg::REC_DATA) begin
			for (int i = 0; i < count; i++) send_byte(any_char(), data_bad_pct);
		end
		send_char(any_char(), 1'b0);
		send_char(any_char(), 1'b0);
	endtask

	task automatic send_random_records(input int upto);
		int pick;
		int n;
		logic [7:0] ch;
		while (chars_sent < upto) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					ch = any_char();
					if (ch == ihex_pkg::CHAR_COLON) ch = ~ch;
					send_char(ch, 1'b0);
				end
			end else if (pick < 65) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(16);
				send_record(ihex_pkg::REC_DATA, 8'(n), 6, 1'b0);
			end else if (pick < 85) begin
				send_record(8'($urandom_range(2, 255)), any_char(), 0, 1'b0);
			end else begin
				send_record(8'($urandom_range(2, 255)), any_char(), 0, 1'b1);
			end
		end
	endtask

	task automatic drain_outputs();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_buffer_length(input logic [15:0] len);
		drain_outputs();
		buffer_length_we <= 1'b1;
		buffer_length_wdata <= len;
		board.buf_len = len;
		@(posedge clk);
		buffer_length_we <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		buffer_length_we <= 1'b0;
		buffer_length_wdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_text(":00000000FF");
		send_text(":02fFfF00aFG/zz");
		send_random_records(200);

		set_buffer_length(board.wr_idx + 16'($urandom_range(1, 60)));
		tx_idle_pct = 81;
		send_random_records(360);

		set_buffer_length(16'hFFFF);
		tx_idle_pct = 0;
		rx_stall_pct = 81;
		send_random_records(520);

		set_buffer_length(16'h0000);
		tx_idle_pct = 33;
		rx_stall_pct = 33;
		send_random_records(600);

		set_buffer_length(16'($urandom_range(65535)));
		send_random_records(730);

		set_buffer_length(16'hFFFF);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_req = 1'b1;
		send_random_records(900);

		if ($urandom_range(1)) begin
			send_text(":00000001FF");
		end else begin
			send_text(":04");
			repeat ($urandom_range(8)) send_char(any_char(), 1'b0);
			send_char(any_char(), 1'b1);
		end
		send_char(any_char(), 1'b1);
		send_char(ihex_pkg::CHAR_COLON, 1'b0);
		send_char(any_char(), 1'($urandom_range(1)));
		s_axis_tvalid <= 1'b0;

		for (int w = 0; w < 50000 && board.pending() != 0; w++) @(posedge clk);
		repeat (8 * SETTLE_CYCLES) @(posedge clk);
		if (board.pending() != 0) begin
			$error("%0d expected results never arrived", board.pending());
			board.mismatches++;
		end

		if (board.mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/ihex_pkg.sv
design/ihex_core.sv
design/intel_hex_record_parser_unit.sv
test/tb_top.sv
